>>> rtl/ptc_pkg.sv
// Shared types and constants for the pressure/temperature compensation pipeline.
// No dependencies; imported by every module of the block.
package ptc_pkg;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               zero_divisor;
    } result_t;

    typedef struct packed {
        logic [15:0]        t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic [15:0]        p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } calib_t;

    // fields that ride along with an item down the pressure path
    typedef struct packed {
        logic signed [15:0] tcent;
        logic               neg;
        logic               zero;
    } side_t;

    typedef enum logic [7:0] {
        REG_TEMP_CALIB   = 8'd0,
        REG_PRESS_FIRST  = 8'd1,
        REG_PRESS_SECOND = 8'd2,
        REG_PRESS_NINTH  = 8'd3
    } reg_index_t;

    localparam int DIV_WIDTH  = 64;
    localparam int REM_W      = 31;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = DIV_WIDTH / DIV_BITS;

    localparam logic signed [33:0] TEMP_OFFSET = 34'sd128000;
    localparam logic signed [63:0] PRESS_SCALE = 64'sd3125;
    localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
    localparam logic signed [63:0] OFFSET_47   = 64'sh0000_8000_0000_0000;

endpackage

>>> rtl/pressure_temperature_compensation_unit.sv
// Top level of the barometric compensation pipeline: config registers and stage chain.
// Depends on ptc_pkg, ptc_temp, ptc_press_pre, ptc_div, ptc_press_post.
//
// Usage:
//   sample channel (sample_valid/sample_stall/sample) carries one raw temperature
//   and raw pressure pair per transaction; result channel (result_valid/
//   result_stall/result) returns one compensated transaction per sample, in order.
//   cfg channel writes calibration words by index (0 temp, 1 and 2 pressure
//   words, 3 P9); cfg_ready is always high, unknown indexes are dropped.
//   Write calibration only while the pipeline is empty.
// Pipeline:
//   3 temperature stages, 6 pressure pre-divide stages,
//   32 divider stages (2 quotient bits each, 64-bit dividend), 6 post stages
//   ending in the output register. Throughput is one transaction per cycle while no stall holds the chain.
// Stall:
//   the whole chain moves under one enable; while result_valid is high and
//   result_stall is asserted, every stage holds and sample_stall is raised,
//   so nothing is lost or repeated.
// Reset:
//   rst_n clears all stage valid bits and the calibration registers to 0.
module pressure_temperature_compensation_unit
    import ptc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [47:0] temp_calib_reg;
    logic [63:0] press_first_reg;
    logic [63:0] press_second_reg;
    logic [15:0] press_ninth_reg;

    calib_t calib;
    logic   adv;

    logic               t_valid;
    logic signed [31:0] t_fine;
    logic signed [15:0] t_tcent;
    logic [19:0]        t_rawp;

    logic                 pre_valid;
    logic [DIV_WIDTH-1:0] pre_nabs;
    logic [REM_W-1:0]     pre_dabs;
    side_t                pre_side;

    logic                 div_valid;
    logic [DIV_WIDTH-1:0] div_quot;
    side_t                div_side;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg   <= '0;
            press_first_reg  <= '0;
            press_second_reg <= '0;
            press_ninth_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TEMP_CALIB:   temp_calib_reg   <= cfg_data[47:0];
                REG_PRESS_FIRST:  press_first_reg  <= cfg_data;
                REG_PRESS_SECOND: press_second_reg <= cfg_data;
                REG_PRESS_NINTH:  press_ninth_reg  <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        calib.t1 = temp_calib_reg[15:0];
        calib.t2 = $signed(temp_calib_reg[31:16]);
        calib.t3 = $signed(temp_calib_reg[47:32]);
        calib.p1 = press_first_reg[15:0];
        calib.p2 = $signed(press_first_reg[31:16]);
        calib.p3 = $signed(press_first_reg[47:32]);
        calib.p4 = $signed(press_first_reg[63:48]);
        calib.p5 = $signed(press_second_reg[15:0]);
        calib.p6 = $signed(press_second_reg[31:16]);
        calib.p7 = $signed(press_second_reg[47:32]);
        calib.p8 = $signed(press_second_reg[63:48]);
        calib.p9 = $signed(press_ninth_reg);
    end

    // one global advance: the chain freezes only when a finished result is held
    assign adv          = !(result_valid && result_stall);
    assign sample_stall = !adv;

    ptc_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sample_valid),
        .sample_in (sample),
        .calib     (calib),
        .out_valid (t_valid),
        .fine      (t_fine),
        .tcent     (t_tcent),
        .raw_p     (t_rawp)
    );

    ptc_press_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (t_valid),
        .fine      (t_fine),
        .tcent     (t_tcent),
        .raw_p     (t_rawp),
        .calib     (calib),
        .out_valid (pre_valid),
        .nabs      (pre_nabs),
        .dabs      (pre_dabs),
        .side      (pre_side)
    );

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (pre_valid),
        .nabs      (pre_nabs),
        .dabs      (pre_dabs),
        .side_in   (pre_side),
        .out_valid (div_valid),
        .quot      (div_quot),
        .side_out  (div_side)
    );

    ptc_press_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (div_valid),
        .quot      (div_quot),
        .side_in   (div_side),
        .calib     (calib),
        .out_valid (result_valid),
        .result    (result)
    );

endmodule

>>> rtl/ptc_temp.sv
// Temperature path: three stages giving the fine term and the centi-degree value.
// Depends on ptc_pkg.
module ptc_temp
    import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  sample_t            sample_in,
    input  calib_t             calib,
    output logic               out_valid,
    output logic signed [31:0] fine,
    output logic signed [15:0] tcent,
    output logic [19:0]        raw_p
);

    logic [2:0]         valid_reg;
    logic signed [31:0] v1_reg, c_reg, fine_b_reg, fine_c_reg;
    logic [19:0]        rawp_a_reg, rawp_b_reg, rawp_c_reg;
    logic signed [15:0] tcent_reg;

    logic [31:0]        a_w, b_w;
    logic signed [31:0] t2_x, t3_x, mul_a_w, bb_w, mul_c_w, fine_next;
    logic signed [35:0] tc_w;
    logic signed [15:0] tcent_next;

    always_comb
    begin
        t2_x      = 32'(calib.t2);
        t3_x      = 32'(calib.t3);
        a_w       = 32'(sample_in.raw_temperature[19:3]) - {15'b0, calib.t1, 1'b0};
        b_w       = 32'(sample_in.raw_temperature[19:4]) - 32'(calib.t1);
        mul_a_w   = $signed(a_w) * t2_x;
        bb_w      = $signed(b_w) * $signed(b_w);
        mul_c_w   = c_reg * t3_x;
        fine_next = v1_reg + (mul_c_w >>> 14);
        tc_w      = (36'(fine_b_reg) * 36'sd5 + 36'sd128) >>> 8;
        if (tc_w < -36'sd32768)
            tcent_next = -16'sd32768;
        else if (tc_w > 36'sd32767)
            tcent_next = 16'sd32767;
        else
            tcent_next = 16'(tc_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg     <= mul_a_w >>> 11;
            c_reg      <= bb_w >>> 12;
            rawp_a_reg <= sample_in.raw_pressure;
            fine_b_reg <= fine_next;
            rawp_b_reg <= rawp_a_reg;
            fine_c_reg <= fine_b_reg;
            tcent_reg  <= tcent_next;
            rawp_c_reg <= rawp_b_reg;
        end
    end

    assign out_valid = valid_reg[2];
    assign fine      = fine_c_reg;
    assign tcent     = tcent_reg;
    assign raw_p     = rawp_c_reg;

endmodule

>>> rtl/ptc_press_pre.sv
// Pressure path ahead of the divider: six stages forming dividend and divisor.
// Depends on ptc_pkg.
module ptc_press_pre
    import ptc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [31:0] fine,
    input  logic signed [15:0] tcent,
    input  logic [19:0]        raw_p,
    input  calib_t             calib,
    output logic               out_valid,
    output logic [DIV_WIDTH-1:0] nabs,
    output logic [REM_W-1:0]   dabs,
    output side_t              side
);

    logic [5:0] valid_reg;
    logic signed [15:0] tc1_reg, tc2_reg, tc3_reg, tc4_reg, tc5_reg;
    logic [19:0] rp1_reg, rp2_reg, rp3_reg;
    logic signed [63:0] sq1_reg, x1p5_1_reg, x1p2_1_reg;
    logic signed [63:0] sqp6_reg, sqp3_reg, x1p5_2_reg, x1p2_2_reg;
    logic signed [63:0] x2_reg, s_reg;
    logic signed [63:0] m_reg, t_reg;
    logic signed [63:0] num_reg;
    logic signed [REM_W-1:0] dv_reg;
    logic [DIV_WIDTH-1:0] nabs_reg;
    logic [REM_W-1:0] dabs_reg;
    side_t side_reg;

    logic signed [33:0] x1_w;
    logic signed [63:0] x2_w, x1b_w, mshift_w;
    logic [20:0] pd_w;

    always_comb
    begin
        x1_w     = 34'(fine) - TEMP_OFFSET;
        x2_w     = sqp6_reg + (x1p5_2_reg <<< 17) + (64'(calib.p4) <<< 35);
        x1b_w    = (sqp3_reg >>> 8) + (x1p2_2_reg <<< 12);
        pd_w     = PRESS_BASE - 21'(rp3_reg);
        mshift_w = m_reg >>> 33;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            sq1_reg    <= 64'(x1_w) * 64'(x1_w);
            x1p5_1_reg <= 64'(x1_w) * 64'(calib.p5);
            x1p2_1_reg <= 64'(x1_w) * 64'(calib.p2);
            tc1_reg    <= tcent;
            rp1_reg    <= raw_p;
            // stage 2
            sqp6_reg   <= sq1_reg * 64'(calib.p6);
            sqp3_reg   <= sq1_reg * 64'(calib.p3);
            x1p5_2_reg <= x1p5_1_reg;
            x1p2_2_reg <= x1p2_1_reg;
            tc2_reg    <= tc1_reg;
            rp2_reg    <= rp1_reg;
            // stage 3
            x2_reg     <= x2_w;
            s_reg      <= OFFSET_47 + x1b_w;
            tc3_reg    <= tc2_reg;
            rp3_reg    <= rp2_reg;
            // stage 4
            m_reg      <= s_reg * $signed({48'b0, calib.p1});
            t_reg      <= $signed({12'b0, pd_w, 31'b0}) - x2_reg;
            tc4_reg    <= tc3_reg;
            // stage 5
            num_reg    <= t_reg * PRESS_SCALE;
            dv_reg     <= $signed(mshift_w[REM_W-1:0]);
            tc5_reg    <= tc4_reg;
            // stage 6: magnitudes and quotient sign
            nabs_reg       <= num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
            dabs_reg       <= dv_reg[REM_W-1] ? REM_W'(-dv_reg) : REM_W'(dv_reg);
            side_reg.tcent <= tc5_reg;
            side_reg.neg   <= num_reg[63] ^ dv_reg[REM_W-1];
            side_reg.zero  <= (dv_reg == '0);
        end
    end

    assign out_valid = valid_reg[5];
    assign nabs      = nabs_reg;
    assign dabs      = dabs_reg;
    assign side      = side_reg;

endmodule

>>> rtl/ptc_div.sv
// Pipelined restoring divider, DIV_BITS quotient bits per stage.
// Depends on ptc_pkg.
module ptc_div
    import ptc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DIV_WIDTH-1:0] nabs,
    input  logic [REM_W-1:0]     dabs,
    input  side_t                side_in,
    output logic                 out_valid,
    output logic [DIV_WIDTH-1:0] quot,
    output side_t                side_out
);

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [DIV_WIDTH-1:0] dq;
    } div_state_t;

    // dq shifts dividend bits out at the top and quotient bits in at the bottom
    function automatic div_state_t div_step(input logic [REM_W-1:0] rem,
                                            input logic [DIV_WIDTH-1:0] dq,
                                            input logic [REM_W-1:0] d);
        logic [REM_W:0] r;
        div_state_t st;
        st.rem = rem;
        st.dq  = dq;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            r     = {st.rem, st.dq[DIV_WIDTH-1]};
            st.dq = {st.dq[DIV_WIDTH-2:0], 1'b0};
            if (r >= {1'b0, d})
            begin
                r        = r - {1'b0, d};
                st.dq[0] = 1'b1;
            end
            st.rem = r[REM_W-1:0];
        end
        return st;
    endfunction

    logic [DIV_STAGES-1:0] valid_reg;
    div_state_t            st_reg   [DIV_STAGES];
    logic [REM_W-1:0]      d_reg    [DIV_STAGES];
    side_t                 side_reg [DIV_STAGES];
    div_state_t            step_w   [DIV_STAGES];

    always_comb
    begin
        step_w[0] = div_step('0, nabs, dabs);
        for (int k = 1; k < DIV_STAGES; k++)
            step_w[k] = div_step(st_reg[k-1].rem, st_reg[k-1].dq, d_reg[k-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]   <= step_w[0];
            d_reg[0]    <= dabs;
            side_reg[0] <= side_in;
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                st_reg[k]   <= step_w[k];
                d_reg[k]    <= d_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign quot      = st_reg[DIV_STAGES-1].dq;
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule

>>> rtl/ptc_press_post.sv
// Pressure path after the divider: sign, P7..P9 correction, saturation, output register.
// Depends on ptc_pkg.
module ptc_press_post
    import ptc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DIV_WIDTH-1:0] quot,
    input  side_t                side_in,
    input  calib_t               calib,
    output logic                 out_valid,
    output result_t              result
);

    logic [5:0] valid_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg;
    side_t sd0_reg, sd1_reg, sd2_reg, sd3_reg, sd4_reg;
    logic [63:0] ll_reg, sq2_reg;
    logic [31:0] hl_reg;
    logic signed [63:0] p8p1_reg, p8p2_reg, p8p3_reg, y1m_reg, sum_reg;
    result_t result_reg;

    logic signed [63:0] ph_w, r_w;
    result_t result_next;

    always_comb
    begin
        ph_w = p0_reg >>> 13;
        r_w  = (sum_reg >>> 8) + (64'(calib.p7) <<< 4);
        result_next.temperature_centi = sd4_reg.tcent;
        result_next.zero_divisor      = sd4_reg.zero;
        if (sd4_reg.zero || r_w[63])
            result_next.pressure_q24_8 = '0;
        else if (r_w[63:32] != '0)
            result_next.pressure_q24_8 = '1;
        else
            result_next.pressure_q24_8 = r_w[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg   <= side_in.neg ? $signed(-quot) : $signed(quot);
            sd0_reg  <= side_in;
            // ph*ph mod 2^64 from 32-bit halves
            ll_reg   <= {32'b0, ph_w[31:0]} * {32'b0, ph_w[31:0]};
            hl_reg   <= ph_w[31:0] * ph_w[63:32];
            p8p1_reg <= p0_reg * 64'(calib.p8);
            p1_reg   <= p0_reg;
            sd1_reg  <= sd0_reg;
            sq2_reg  <= ll_reg + {hl_reg[30:0], 33'b0};
            p8p2_reg <= p8p1_reg;
            p2_reg   <= p1_reg;
            sd2_reg  <= sd1_reg;
            y1m_reg  <= $signed(sq2_reg) * 64'(calib.p9);
            p8p3_reg <= p8p2_reg;
            p3_reg   <= p2_reg;
            sd3_reg  <= sd2_reg;
            sum_reg  <= p3_reg + (y1m_reg >>> 25) + (p8p3_reg >>> 19);
            sd4_reg  <= sd3_reg;
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_reg[5];
    assign result    = result_reg;

endmodule

>>> rtl/ptc_checker.sv
// Port-level checks for the compensation unit, bound to the top level.
// Depends on ptc_pkg and pressure_temperature_compensation_unit.
module ptc_checker
    import ptc_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result,
    input logic    cfg_valid,
    input logic    cfg_ready
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("held result transaction changed");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("input stalled without a held result");

    a_zero_press: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.zero_divisor |-> result.pressure_q24_8 == '0)
        else $error("zero divisor with nonzero pressure");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind pressure_temperature_compensation_unit ptc_checker u_ptc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
